// ===== rtl/jse_pkg.sv =====
// jse_pkg: shared types, character codes and helpers for the json string escaper
// used by jse_decode and json_string_escaper; no dependencies

package jse_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 16;
  localparam int unsigned IdxW  = 3;

  // how an accepted word expands on the output side
  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_PAIR,
    KIND_UNI,
    KIND_STATUS
  } kind_e;

  localparam logic [ByteW-1:0] CH_QUOTE   = 8'h22;
  localparam logic [ByteW-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [ByteW-1:0] CH_LF      = 8'h0A;
  localparam logic [ByteW-1:0] CH_CR      = 8'h0D;
  localparam logic [ByteW-1:0] CH_TAB     = 8'h09;
  localparam logic [ByteW-1:0] CH_N       = 8'h6E;
  localparam logic [ByteW-1:0] CH_R       = 8'h72;
  localparam logic [ByteW-1:0] CH_T       = 8'h74;
  localparam logic [ByteW-1:0] CH_U       = 8'h75;
  localparam logic [ByteW-1:0] CH_ZERO    = 8'h30;
  localparam logic [ByteW-1:0] CTRL_LIMIT = 8'h20;

  // index of the last output word of each expansion
  localparam logic [IdxW-1:0] LAST_SINGLE = 3'd0;
  localparam logic [IdxW-1:0] LAST_PAIR   = 3'd1;
  localparam logic [IdxW-1:0] LAST_UNI    = 3'd5;

  localparam logic [IdxW-1:0] LEN_PLAIN = 3'd1;
  localparam logic [IdxW-1:0] LEN_PAIR  = 3'd2;
  localparam logic [IdxW-1:0] LEN_UNI   = 3'd6;

  // register map
  localparam logic [2:0] ADDR_CAPACITY = 3'd0;
  localparam logic [CntW-1:0] CAPACITY_RESET = 16'd256;

  typedef struct packed {
    logic            load;
    kind_e           kind;
    logic [ByteW-1:0] sec;
    logic [CntW-1:0] count_next;
    logic            stopped_next;
    logic            ovf_next;
    logic            status;
  } dec_t;

  // lower-case hex digit
  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib);
    logic [ByteW-1:0] ext;
    ext = {4'b0000, nib};
    if (nib < 4'd10) begin
      hex_char = ext + 8'h30;
    end else begin
      hex_char = ext + 8'h57;
    end
  endfunction

endpackage

// ===== rtl/jse_decode.sv =====
// jse_decode: classifies one input byte against the running string state
// depends on jse_pkg

module jse_decode
  import jse_pkg::*;
(
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             no_byte_i,
  input  logic             is_last_i,
  input  logic [CntW-1:0]  count_i,
  input  logic             stopped_i,
  input  logic             ovf_i,
  input  logic [CntW-1:0]  capacity_i,
  output dec_t             dec_o
);

  logic            ovf;
  logic            stop;
  logic            active;
  logic            room2_gone;
  logic            room6_gone;
  logic [IdxW-1:0] n;
  logic [CntW:0]   cnt_ext;
  logic [CntW:0]   cap_ext;
  logic [CntW-1:0] count_sum;
  kind_e           kind;
  logic [ByteW-1:0] sec;

  always_comb begin
    cnt_ext    = {1'b0, count_i};
    cap_ext    = {1'b0, capacity_i};
    room2_gone = (cnt_ext + 17'd2) >= cap_ext;
    room6_gone = (cnt_ext + 17'd6) >= cap_ext;
    ovf        = ovf_i | (capacity_i == '0);
    stop       = stopped_i;
    active     = !no_byte_i && !stopped_i && !ovf;
    n          = '0;
    kind       = KIND_PLAIN;
    sec        = in_byte_i;

    if (active) begin
      priority if (room2_gone) begin
        stop = 1'b1;
      end else if (in_byte_i == CH_QUOTE || in_byte_i == CH_BSLASH) begin
        kind = KIND_PAIR;
        n    = LEN_PAIR;
      end else if (in_byte_i == CH_LF) begin
        kind = KIND_PAIR;
        sec  = CH_N;
        n    = LEN_PAIR;
      end else if (in_byte_i == CH_CR) begin
        kind = KIND_PAIR;
        sec  = CH_R;
        n    = LEN_PAIR;
      end else if (in_byte_i == CH_TAB) begin
        kind = KIND_PAIR;
        sec  = CH_T;
        n    = LEN_PAIR;
      end else if (in_byte_i < CTRL_LIMIT) begin
        if (room6_gone) begin
          ovf = 1'b1;
        end else begin
          kind = KIND_UNI;
          n    = LEN_UNI;
        end
      end else begin
        n = LEN_PLAIN;
      end
    end

    if (n == '0) begin
      kind = KIND_STATUS;
    end

    count_sum = count_i + {{(CntW-IdxW){1'b0}}, n};

    dec_o.load   = (n != '0) || is_last_i;
    dec_o.kind   = kind;
    dec_o.sec    = sec;
    dec_o.status = ovf;
    if (is_last_i) begin
      dec_o.count_next   = '0;
      dec_o.stopped_next = 1'b0;
      dec_o.ovf_next     = 1'b0;
    end else begin
      dec_o.count_next   = count_sum;
      dec_o.stopped_next = stop;
      dec_o.ovf_next     = ovf;
    end
  end

endmodule

// ===== rtl/json_string_escaper.sv =====
// json_string_escaper: top level, escapes a byte stream for a json string
// depends on jse_pkg and jse_decode

// Takes one string byte per input word and emits its json-escaped form one
// byte per output word. Quote, backslash, newline, return and tab expand to
// two words and other control bytes to the six-word \u00xx form, and such a
// byte holds the input until its last word has gone to the output register.
// The rate is set by the expansion register, which hands one word per cycle to
// the output register; with the sink always ready, plain text streams at one
// byte per clock. The running length is checked against the capacity register
// (byte address 0, reset 256): once fewer than three slots remain the rest of
// the string is dropped with status ok, a \u escape that does not fit or a
// zero capacity flags overflow. The word that ends the string (s_axis_tlast)
// yields string_done with the final length and status on its last result, or
// one status-only word (tuser low) if it produced no byte.

module json_string_escaper
  import jse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] no_byte
  input  logic        s_axis_tlast,   // is_last

  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [8] string_done, [9] status,
                                      // [25:10] out_length, [31:26] zero
  output logic        m_axis_tuser,   // [0] has_byte
  output logic        m_axis_tlast,   // run_last

  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration register
  logic [CntW-1:0] capacity_q;

  // per-string state
  logic [CntW-1:0] count_q;
  logic            stopped_q;
  logic            ovf_q;

  // expansion register: the word being broken into output bytes
  logic             exp_valid_q, exp_valid_d;
  kind_e            kind_q;
  logic [ByteW-1:0] sec_q;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  base_q;
  logic             last_q;
  logic             stat_q;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic             has_byte_q;
  logic             run_last_q;
  logic             done_q;
  logic             status_q;
  logic [CntW-1:0]  len_q;

  dec_t             dec;
  logic             accept;
  logic             load_exp;
  logic             out_load;
  logic             at_last;
  logic [IdxW-1:0]  last_idx;
  logic [ByteW-1:0] cur_byte;
  logic             cur_has;
  logic [CntW-1:0]  cur_len;

  // ---------------------------------------------------------------------------
  // apb register port, single register, writes take effect at the access edge
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    if (paddr == ADDR_CAPACITY) begin
      prdata = {16'b0, capacity_q};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
      capacity_q <= pwdata[CntW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // decode of the incoming word against the state left by earlier words
  // ---------------------------------------------------------------------------
  jse_decode u_decode (
    .in_byte_i  (s_axis_tdata),
    .no_byte_i  (s_axis_tuser),
    .is_last_i  (s_axis_tlast),
    .count_i    (count_q),
    .stopped_i  (stopped_q),
    .ovf_i      (ovf_q),
    .capacity_i (capacity_q),
    .dec_o      (dec)
  );

  // ---------------------------------------------------------------------------
  // expansion: select the current byte of the escape sequence
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (kind_q)
      KIND_PAIR: last_idx = LAST_PAIR;
      KIND_UNI:  last_idx = LAST_UNI;
      default:   last_idx = LAST_SINGLE;
    endcase
  end

  always_comb begin
    cur_has  = 1'b1;
    cur_byte = sec_q;
    unique case (kind_q)
      KIND_PLAIN: cur_byte = sec_q;
      KIND_PAIR: begin
        cur_byte = (idx_q == '0) ? CH_BSLASH : sec_q;
      end
      KIND_UNI: begin
        unique case (idx_q)
          3'd0:    cur_byte = CH_BSLASH;
          3'd1:    cur_byte = CH_U;
          3'd2:    cur_byte = CH_ZERO;
          3'd3:    cur_byte = CH_ZERO;
          3'd4:    cur_byte = hex_char(sec_q[7:4]);
          default: cur_byte = hex_char(sec_q[3:0]);
        endcase
      end
      KIND_STATUS: begin
        cur_has  = 1'b0;
        cur_byte = '0;
      end
    endcase
    // length counts this word's byte
    if (cur_has) begin
      cur_len = base_q + {{(CntW-IdxW){1'b0}}, idx_q} + 16'd1;
    end else begin
      cur_len = base_q;
    end
  end

  assign at_last       = (idx_q == last_idx);
  assign out_load      = exp_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !exp_valid_q || (out_load && at_last);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // a word that emits nothing and does not end the string leaves no result
  assign load_exp      = accept && dec.load;

  always_comb begin
    exp_valid_d = exp_valid_q;
    idx_d       = idx_q;
    if (load_exp) begin
      exp_valid_d = 1'b1;
      idx_d       = '0;
    end else if (out_load) begin
      if (at_last) begin
        exp_valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      stopped_q   <= 1'b0;
      ovf_q       <= 1'b0;
      exp_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= dec.count_next;
        stopped_q <= dec.stopped_next;
        ovf_q     <= dec.ovf_next;
      end
      exp_valid_q <= exp_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_exp) begin
      kind_q <= dec.kind;
      sec_q  <= dec.sec;
      base_q <= count_q;
      last_q <= s_axis_tlast;
      stat_q <= dec.status;
    end
    if (out_load) begin
      out_byte_q <= cur_byte;
      has_byte_q <= cur_has;
      run_last_q <= at_last;
      done_q     <= at_last && last_q;
      status_q   <= at_last && last_q && stat_q;
      len_q      <= cur_len;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, len_q, status_q, done_q, out_byte_q};
  assign m_axis_tuser  = has_byte_q;
  assign m_axis_tlast  = run_last_q;

endmodule

// ===== dv/tb_json_string_escaper.sv =====
// tb_json_string_escaper: self-checking testbench for the json string escaper
// needs jse_pkg and json_string_escaper; streams strings in, checks every escaped word out
// a cycle-free predictor tracks the per-string count, drop and overflow state

`timescale 1ns / 1ps

module tb_json_string_escaper
  import jse_pkg::*;
();

  // one string byte as offered on the input stream
  typedef struct {
    logic [7:0] ch;
    logic       nob;
    logic       lst;
  } in_word_t;

  // one escaped word as it should leave the block
  typedef struct {
    logic [7:0]  ch;
    logic        has;
    logic        run_last;
    logic        done;
    logic        status;
    logic [15:0] len;
  } esc_word_t;

  localparam int HoldCycles = 300;
  localparam int DrainGuard = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] in_byte
  logic        s_axis_tuser = 1'b0; // [0] no_byte
  logic        s_axis_tlast = 1'b0; // is_last

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [7:0] out_byte, [8] string_done, [9] status,
                                    // [25:10] out_length, [31:26] zero
  logic        m_axis_tuser;        // [0] has_byte
  logic        m_axis_tlast;        // run_last

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  json_string_escaper DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // shared state
  // --------------------------------------------------------------------------

  in_word_t  text_q[$];     // string bytes waiting for the driver
  esc_word_t escaped_q[$];  // escaped words still owed by the block

  // mirror of the capacity register and the per-string state
  logic [15:0] cap_q = CAPACITY_RESET;
  logic [15:0] wr_cnt = '0;
  logic        stop_f = 1'b0;
  logic        ovf_f = 1'b0;

  string hex_set = "0123456789abcdef";

  int errors = 0;
  int words_queued = 0;
  int words_in = 0;
  int words_out = 0;
  int strings_done = 0;
  int strings_ovf = 0;

  // idle shaping, set per phase by the sequence
  logic calm = 1'b1;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   burst_left = 0;
  int   gap_left = 0;

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // predictor: escape one accepted byte and queue the words it must produce
  // --------------------------------------------------------------------------

  function automatic void escape_byte(input logic [7:0] ch, input logic nob,
                                      input logic lst);
    esc_word_t  res[6];
    logic [7:0] seq[6];
    int         n;
    n = 0;
    // zero capacity poisons the whole string, whatever the word carries
    if (cap_q == 16'd0) begin
      ovf_f = 1'b1;
    end
    if (!nob && !stop_f && !ovf_f) begin
      if (32'(wr_cnt) + 32'd2 >= 32'(cap_q)) begin
        // under three slots left: drop silently, status stays ok
        stop_f = 1'b1;
      end else if (ch == CH_QUOTE || ch == CH_BSLASH) begin
        seq[0] = CH_BSLASH;
        seq[1] = ch;
        n = 2;
      end else if (ch == CH_LF) begin
        seq[0] = CH_BSLASH;
        seq[1] = CH_N;
        n = 2;
      end else if (ch == CH_CR) begin
        seq[0] = CH_BSLASH;
        seq[1] = CH_R;
        n = 2;
      end else if (ch == CH_TAB) begin
        seq[0] = CH_BSLASH;
        seq[1] = CH_T;
        n = 2;
      end else if (ch < CTRL_LIMIT) begin
        // the six-byte \u00xx form either fits whole or flags overflow
        if (32'(wr_cnt) + 32'd6 >= 32'(cap_q)) begin
          ovf_f = 1'b1;
        end else begin
          seq[0] = CH_BSLASH;
          seq[1] = CH_U;
          seq[2] = CH_ZERO;
          seq[3] = CH_ZERO;
          seq[4] = hex_set[ch[7:4]];
          seq[5] = hex_set[ch[3:0]];
          n = 6;
        end
      end else begin
        seq[0] = ch;
        n = 1;
      end
    end

    for (int k = 0; k < n; k++) begin
      wr_cnt = wr_cnt + 16'd1;
      res[k] = '{seq[k], 1'b1, 1'b0, 1'b0, 1'b0, wr_cnt};
    end

    // end of string: status rides on the last byte, or on a status-only word
    if (lst) begin
      if (n == 0) begin
        res[0] = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, wr_cnt};
        n = 1;
      end
      res[n-1].done = 1'b1;
      res[n-1].status = ovf_f;
      wr_cnt = '0;
      stop_f = 1'b0;
      ovf_f = 1'b0;
    end

    if (n > 0) begin
      res[n-1].run_last = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      escaped_q.push_back(res[k]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // input driver: bursts of words from text_q with random gaps in between
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : drv
    in_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
      s_axis_tlast <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      // the word on the bus is taken at this edge: predict it now
      if (s_axis_tvalid && s_axis_tready) begin
        escape_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        words_in++;
      end
      // the bus is free for a new word unless one is still waiting
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (text_q.size() > 0) begin
          w = text_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= w.ch;
          s_axis_tuser <= w.nob;
          s_axis_tlast <= w.lst;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            if (calm || $urandom_range(0, 2) == 0) begin
              gap_left <= 0;
            end else begin
              gap_left <= $urandom_range(1, 6);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output sink: short random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
      stall_left <= 0;
    end else if (hold_req != hold_seen) begin
      // long hold-off so the block backs up and throttles its input
      hold_seen <= hold_req;
      hold_left <= HoldCycles - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: compare every accepted word with the oldest expectation
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin : mon
    esc_word_t got;
    esc_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[7:0], m_axis_tuser, m_axis_tlast, m_axis_tdata[8],
              m_axis_tdata[9], m_axis_tdata[25:10]};
      words_out++;
      if (got.done) begin
        strings_done++;
        if (got.status) begin
          strings_ovf++;
        end
      end
      if (escaped_q.size() == 0) begin
        flag_mismatch($sformatf("output word %0d arrived with nothing pending", words_out));
      end else begin
        want = escaped_q.pop_front();
        if (got.ch !== want.ch)
          flag_mismatch($sformatf("word %0d out_byte %h, want %h", words_out, got.ch, want.ch));
        if (got.has !== want.has)
          flag_mismatch($sformatf("word %0d has_byte %b, want %b", words_out, got.has,
                                  want.has));
        if (got.run_last !== want.run_last)
          flag_mismatch($sformatf("word %0d run_last %b, want %b", words_out, got.run_last,
                                  want.run_last));
        if (got.done !== want.done)
          flag_mismatch($sformatf("word %0d string_done %b, want %b", words_out, got.done,
                                  want.done));
        if (got.status !== want.status)
          flag_mismatch($sformatf("word %0d status %b, want %b", words_out, got.status,
                                  want.status));
        if (got.len !== want.len)
          flag_mismatch($sformatf("word %0d out_length %0d, want %0d", words_out, got.len,
                                  want.len));
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence helpers
  // --------------------------------------------------------------------------

  task automatic add_word(input logic [7:0] ch, input logic nob, input logic lst);
    text_q.push_back('{ch, nob, lst});
    words_queued++;
  endtask

  // capacity write: setup cycle, then access until pready
  task automatic cap_write(input logic [15:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_CAPACITY;
    pwdata <= {16'h0000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_q <= value;
  endtask

  // sender waits until all words are taken and every escaped word is back,
  // then lets a dropped or status-free word clear the pipeline
  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((words_in != words_queued || escaped_q.size() != 0) && guard < DrainGuard) begin
      @(posedge clk_i);
      guard++;
    end
    if (guard >= DrainGuard) begin
      flag_mismatch($sformatf("%0d escaped words never arrived", escaped_q.size()));
    end
    repeat (10) @(posedge clk_i);
  endtask

  // mostly printable text, with a fair share of escapes, control and high bytes
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return CH_QUOTE;
          1: return CH_BSLASH;
          2: return CH_LF;
          3: return CH_CR;
          default: return CH_TAB;
        endcase
      end
      1: return 8'($urandom_range(0, 31));
      2: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  // random strings of 1..12 bytes, sprinkled with byte-less words and empty
  // strings; an open phase leaves its last string unterminated
  task automatic queue_strings(input int count, input bit close);
    int run_left;
    int r;
    run_left = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 29);
      if (r == 0) begin
        add_word(8'($urandom), 1'b1, 1'b1);
        run_left = $urandom_range(1, 12);
      end else if (r < 4) begin
        add_word(8'($urandom), 1'b1, 1'b0);
      end else begin
        run_left--;
        add_word(pick_char(), 1'b0, run_left == 0);
        if (run_left == 0) begin
          run_left = $urandom_range(1, 12);
        end
      end
    end
    add_word(pick_char(), 1'b0, close);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every escape class at the reset capacity
    calm <= 1'b1;
    cap_write(16'd256);
    add_word("A", 1'b0, 1'b0);
    add_word(8'h00, 1'b0, 1'b0);       // nul goes out as \u0000
    add_word(8'hFF, 1'b0, 1'b0);
    add_word(CH_QUOTE, 1'b0, 1'b0);
    add_word(CH_BSLASH, 1'b0, 1'b0);
    add_word(CH_LF, 1'b0, 1'b0);
    add_word(CH_CR, 1'b0, 1'b0);
    add_word(CH_TAB, 1'b0, 1'b0);
    add_word(8'h1F, 1'b0, 1'b0);
    add_word(8'h20, 1'b0, 1'b0);
    add_word(8'h7F, 1'b0, 1'b0);
    add_word(8'h80, 1'b0, 1'b0);
    add_word(8'hAA, 1'b1, 1'b0);       // byte-less word mid-string: nothing out
    add_word(8'h5A, 1'b0, 1'b1);       // status rides on the last byte
    add_word(8'h55, 1'b1, 1'b1);       // empty string: one status-only word
    wait_drained();

    // three slots short: fourth byte and the rest dropped, status ok
    cap_write(16'd5);
    add_word("a", 1'b0, 1'b0);
    add_word("b", 1'b0, 1'b0);
    add_word("c", 1'b0, 1'b0);
    add_word("d", 1'b0, 1'b1);
    wait_drained();

    // \u escape that does not fit flags overflow
    cap_write(16'd8);
    add_word("x", 1'b0, 1'b0);
    add_word("y", 1'b0, 1'b0);
    add_word(8'h01, 1'b0, 1'b1);
    wait_drained();

    // zero capacity is an error for the whole string
    cap_write(16'd0);
    add_word("q", 1'b0, 1'b1);
    wait_drained();

    cap_write(16'hFFFF);
    add_word(CH_BSLASH, 1'b0, 1'b1);
    wait_drained();

    // random: full capacity, sink held off while the sender keeps offering
    calm <= 1'b1;
    cap_write(16'hFFFF);
    queue_strings(25, 1'b1);
    hold_req <= hold_req + 1;
    wait_drained();

    calm <= 1'b0;
    cap_write(16'd3);
    queue_strings(20, 1'b1);
    wait_drained();

    cap_write(16'd24);
    queue_strings(15, 1'b1);
    wait_drained();

    cap_write(16'($urandom_range(0, 65535)));
    queue_strings(15, 1'b1);
    wait_drained();

    // string left open, capacity raised under it, then finished
    cap_write(16'd12);
    queue_strings(20, 1'b0);
    wait_drained();

    cap_write(16'd40);
    queue_strings(20, 1'b1);
    wait_drained();

    cap_write(16'd0);
    queue_strings(8, 1'b1);
    wait_drained();

    repeat (20) @(posedge clk_i);
    $display("run covered %0d input words, %0d escaped words, %0d strings (%0d overflowed)",
             words_in, words_out, strings_done, strings_ovf);
    $display("capacities from 0 to 65535, one long sink hold-off, one string across a write");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/jse_pkg.sv
rtl/jse_decode.sv
rtl/json_string_escaper.sv
dv/tb_json_string_escaper.sv
